FILE: src/rcst_pkg.sv
// Package for the range clamp segment tree: sizes, command codes, tag and request types.
// Shared by rcst_tag_ram, rcst_engine and range_clamp_segment_tree. Depends on nothing.
package rcst_pkg;

    // Tree size; NUM_CELLS must be a power of two (heap numbering, root at node 1).
    localparam int NUM_CELLS   = 1024;
    localparam int LOG_CELLS   = $clog2(NUM_CELLS);
    localparam int HEIGHT_BITS = 16;
    localparam int POS_BITS    = LOG_CELLS;
    localparam int NODE_BITS   = LOG_CELLS + 1;
    localparam int TREE_NODES  = 2 * NUM_CELLS;
    localparam int LEN_BITS    = $clog2(NUM_CELLS + 1);
    localparam int LVL_BITS    = $clog2(LOG_CELLS + 2);

    localparam logic [HEIGHT_BITS-1:0] HEIGHT_MAX = '1;

    localparam logic [1:0] CMD_RAISE = 2'd0;
    localparam logic [1:0] CMD_LOWER = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    typedef struct packed {
        logic [HEIGHT_BITS-1:0] lo;
        logic [HEIGHT_BITS-1:0] up;
    } t_tag;

    localparam t_tag TAG_IDENTITY = '{lo: '0, up: HEIGHT_MAX};

    typedef struct packed {
        logic [1:0]             cmd;
        logic [POS_BITS-1:0]    range_start;
        logic [POS_BITS-1:0]    range_end;
        logic [HEIGHT_BITS-1:0] bound;
        logic [POS_BITS-1:0]    cell_index;
    } t_req;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } t_eng_stat;

    // Apply clamp "by" on top of tag t: v -> min(max(v, lo), up).
    function automatic t_tag clamp_tag(input t_tag t, input t_tag by);
        t_tag res;
        res.lo = (t.lo > by.lo) ? t.lo : by.lo;
        res.lo = (res.lo < by.up) ? res.lo : by.up;
        res.up = (t.up > by.lo) ? t.up : by.lo;
        res.up = (res.up < by.up) ? res.up : by.up;
        return res;
    endfunction

endpackage

FILE: src/rcst_tag_ram.sv
// Tag memory: one write port, two registered read ports, one (lower, upper) tag per node.
// Depends on rcst_pkg.
module rcst_tag_ram
    import rcst_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [NODE_BITS-1:0] i_waddr,
    input  t_tag                 i_wdata,
    input  logic [NODE_BITS-1:0] i_raddr_a,
    output t_tag                 o_rdata_a,
    input  logic [NODE_BITS-1:0] i_raddr_b,
    output t_tag                 o_rdata_b
);

    t_tag r_mem [TREE_NODES];
    t_tag r_rdata_a;
    t_tag r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

FILE: src/rcst_engine.sv
// Tree sequencer: clearing pass, read walk, push-down along both range edges, cover apply.
// Depends on rcst_pkg and rcst_tag_ram.
module rcst_engine
    import rcst_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_clear,
    input  logic [LEN_BITS-1:0]    i_wall_len,
    input  logic                   i_start,
    input  t_req                   i_req,
    input  logic                   i_res_take,
    output t_eng_stat              o_stat,
    output logic [HEIGHT_BITS-1:0] o_res
);

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_PUSH, ST_COV_CHK, ST_COV_RD, ST_COV_WR, ST_DONE
    } t_state;

    t_state                 r_state;
    logic [NODE_BITS-1:0]   r_clr_addr;
    logic [LVL_BITS-1:0]    r_lvl;
    logic [1:0]             r_step;
    logic                   r_side;
    logic [POS_BITS-1:0]    r_pos;
    logic [POS_BITS-1:0]    r_a;
    logic [POS_BITS-1:0]    r_b;
    logic [NODE_BITS:0]     r_l;
    logic [NODE_BITS:0]     r_r;
    logic [NODE_BITS-1:0]   r_node;
    t_tag                   r_tag;
    t_tag                   r_acc;
    t_tag                   r_ptag;
    logic [HEIGHT_BITS-1:0] r_res;

    logic                 w_we;
    logic [NODE_BITS-1:0] w_waddr;
    t_tag                 w_wdata;
    logic [NODE_BITS-1:0] w_ra;
    logic [NODE_BITS-1:0] w_rb;
    t_tag                 w_rd_a;
    t_tag                 w_rd_b;
    logic [NODE_BITS-1:0] w_pa;
    logic [NODE_BITS-1:0] w_pb;
    logic [NODE_BITS-1:0] w_p;
    logic [NODE_BITS-1:0] w_c0;
    logic [NODE_BITS-1:0] w_c1;
    t_tag                 w_acc_n;
    logic [LEN_BITS-1:0]  w_len_m1;

    // Node on the path to a cell at a given depth (root is depth 0).
    function automatic logic [NODE_BITS-1:0] node_at(input logic [POS_BITS-1:0] pos,
                                                    input logic [LVL_BITS-1:0] lvl);
        logic [NODE_BITS-1:0] full;
        full = {1'b1, pos};
        return full >> (LVL_BITS'(LOG_CELLS) - lvl);
    endfunction

    rcst_tag_ram u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_ra),
        .o_rdata_a (w_rd_a),
        .i_raddr_b (w_rb),
        .o_rdata_b (w_rd_b)
    );

    assign w_pa     = node_at(r_a, r_lvl);
    assign w_pb     = node_at(r_b, r_lvl);
    assign w_p      = r_side ? w_pb : w_pa;
    assign w_c0     = {w_p[NODE_BITS-2:0], 1'b0};
    assign w_c1     = {w_p[NODE_BITS-2:0], 1'b1};
    assign w_acc_n  = clamp_tag(w_rd_a, r_acc);
    assign w_len_m1 = i_wall_len - LEN_BITS'(1);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_p;
        w_wdata = TAG_IDENTITY;
        w_ra    = w_p;
        w_rb    = w_c0;
        case (r_state)
            ST_CLEAR: begin
                // internal nodes open, leaves at zero height
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
                w_wdata = '{lo: '0, up: r_clr_addr[NODE_BITS-1] ? '0 : HEIGHT_MAX};
            end
            ST_READ: begin
                w_ra = node_at(r_pos, r_lvl);
            end
            ST_PUSH: begin
                case (r_step)
                    2'd1: begin
                        w_we    = 1'b1;
                        w_waddr = w_c0;
                        w_wdata = clamp_tag(w_rd_b, w_rd_a);
                        w_ra    = w_c1;
                    end
                    2'd2: begin
                        w_we    = 1'b1;
                        w_waddr = w_c1;
                        w_wdata = clamp_tag(w_rd_a, r_ptag);
                    end
                    2'd3: begin
                        w_we    = 1'b1;
                        w_waddr = w_p;
                        w_wdata = TAG_IDENTITY;
                    end
                    default: begin
                        w_ra = w_p;
                        w_rb = w_c0;
                    end
                endcase
            end
            ST_COV_RD: begin
                w_ra = r_node;
            end
            ST_COV_WR: begin
                w_we    = 1'b1;
                w_waddr = r_node;
                w_wdata = clamp_tag(w_rd_a, r_tag);
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + NODE_BITS'(1);
                    if (&r_clr_addr) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_start) begin
                        r_pos  <= i_req.cell_index;
                        r_a    <= i_req.range_start;
                        r_b    <= ({1'b0, i_req.range_end} >= i_wall_len) ?
                                  w_len_m1[POS_BITS-1:0] : i_req.range_end;
                        r_tag  <= (i_req.cmd == CMD_RAISE) ?
                                  t_tag'{lo: i_req.bound, up: HEIGHT_MAX} :
                                  t_tag'{lo: '0, up: i_req.bound};
                        r_lvl  <= '0;
                        r_step <= '0;
                        r_side <= 1'b0;
                        r_acc  <= TAG_IDENTITY;
                        if (i_req.cmd == CMD_READ) begin
                            if ({1'b0, i_req.cell_index} >= i_wall_len) begin
                                r_res   <= '0;
                                r_state <= ST_DONE;
                            end else begin
                                r_state <= ST_READ;
                            end
                        end else if ((i_req.cmd == CMD_RAISE || i_req.cmd == CMD_LOWER) &&
                                     i_req.range_start <= i_req.range_end &&
                                     {1'b0, i_req.range_start} < i_wall_len) begin
                            r_state <= ST_PUSH;
                        end
                    end
                end
                ST_READ: begin
                    // reads issue every cycle; data of the level before is folded in
                    if (r_lvl != '0) begin
                        r_acc <= w_acc_n;
                    end
                    if (r_lvl == LVL_BITS'(LOG_CELLS + 1)) begin
                        r_res   <= (w_acc_n.lo > w_acc_n.up) ? w_acc_n.lo : w_acc_n.up;
                        r_state <= ST_DONE;
                    end else begin
                        r_lvl <= r_lvl + LVL_BITS'(1);
                    end
                end
                ST_PUSH: begin
                    r_step <= r_step + 2'd1;
                    if (r_step == 2'd1) begin
                        r_ptag <= w_rd_a;
                    end
                    if (r_step == 2'd3) begin
                        if (!r_side && w_pa != w_pb) begin
                            r_side <= 1'b1;
                        end else begin
                            r_side <= 1'b0;
                            if (r_lvl == LVL_BITS'(LOG_CELLS - 1)) begin
                                r_l     <= (NODE_BITS+1)'(NUM_CELLS) + (NODE_BITS+1)'(r_a);
                                r_r     <= (NODE_BITS+1)'(NUM_CELLS) + (NODE_BITS+1)'(r_b)
                                           + (NODE_BITS+1)'(1);
                                r_state <= ST_COV_CHK;
                            end else begin
                                r_lvl <= r_lvl + LVL_BITS'(1);
                            end
                        end
                    end
                end
                ST_COV_CHK: begin
                    if (r_l >= r_r) begin
                        r_state <= ST_IDLE;
                    end else if (r_l[0]) begin
                        r_node  <= r_l[NODE_BITS-1:0];
                        r_l     <= r_l + (NODE_BITS+1)'(1);
                        r_state <= ST_COV_RD;
                    end else if (r_r[0]) begin
                        r_node  <= r_r[NODE_BITS-1:0] - NODE_BITS'(1);
                        r_r     <= r_r - (NODE_BITS+1)'(1);
                        r_state <= ST_COV_RD;
                    end else begin
                        r_l <= r_l >> 1;
                        r_r <= r_r >> 1;
                    end
                end
                ST_COV_RD: begin
                    r_state <= ST_COV_WR;
                end
                ST_COV_WR: begin
                    r_state <= ST_COV_CHK;
                end
                ST_DONE: begin
                    if (i_res_take) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_stat.idle      = (r_state == ST_IDLE);
    assign o_stat.res_valid = (r_state == ST_DONE);
    assign o_res            = r_res;

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !i_res_take && !i_clear) |=> (r_state == ST_DONE && $stable(r_res)))
        else $error("finished read result lost before delivery");

    a_push_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PUSH) |-> (r_lvl < LVL_BITS'(LOG_CELLS)))
        else $error("push-down beyond the last internal level");

    a_cover_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COV_RD) |-> (r_node != '0))
        else $error("cover apply on unused node zero");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_DONE) |-> !w_we)
        else $error("tag memory written while idle");

endmodule

FILE: src/range_clamp_segment_tree.sv
// Top level of the range clamp segment tree: channels, wall length register, output register.
// Depends on rcst_pkg, rcst_engine (and through it rcst_tag_ram).
//
// Use: requests enter on i_valid / o_stall with cmd, range and bound or cell index.
// Raise lifts cells start..end to at least bound, lower cuts them to at most bound;
// both give no result. Read returns the cell's height on o_valid / i_stall.
// Reads past the wall length return zero; empty ranges and unused commands do nothing.
// Flow: one request at a time. A read walks the path with one tag read per level,
// issued back to back from the root to the leaf; its result then goes to the output register.
// An update pushes tags down along the paths of both range edges (up to 2 nodes per level)
// on the single write port: read the node and its left child, write the left child, write
// the right child, clear the node; then it clamps each covering node (check, read, write).
// Reset and every wall length write start a clearing pass over all 2048 nodes, one node a
// cycle, during which o_stall is high; configuration writes are always taken.
// A finished read waits in the output register while the receiver stalls; the tree
// can take and process the next request meanwhile, and only a second read result
// waits in the engine until the register frees.
module range_clamp_segment_tree
    import rcst_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // request channel
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [1:0]             i_cmd,
    input  logic [POS_BITS-1:0]    i_range_start,
    input  logic [POS_BITS-1:0]    i_range_end,
    input  logic [HEIGHT_BITS-1:0] i_bound_height,
    input  logic [POS_BITS-1:0]    i_cell_index,
    // result channel
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [HEIGHT_BITS-1:0] o_cell_height,
    // wall length write
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [LEN_BITS-1:0]    i_cfg_wall_length
);

    localparam logic [LEN_BITS-1:0] LEN_MAX = LEN_BITS'(NUM_CELLS);

    logic [LEN_BITS-1:0]    r_wall_len;
    logic                   r_out_valid;
    logic [HEIGHT_BITS-1:0] r_out_height;

    t_req                   w_req;
    t_eng_stat              w_stat;
    logic [HEIGHT_BITS-1:0] w_res;
    logic                   w_start;
    logic                   w_take;
    logic [LEN_BITS-1:0]    n_wall_len;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = !w_stat.idle;
    assign w_start     = i_valid && w_stat.idle;
    // result moves on when the output register is empty or being emptied
    assign w_take      = w_stat.res_valid && (!r_out_valid || !i_stall);

    assign w_req.cmd         = i_cmd;
    assign w_req.range_start = i_range_start;
    assign w_req.range_end   = i_range_end;
    assign w_req.bound       = i_bound_height;
    assign w_req.cell_index  = i_cell_index;

    // saturate the written length to 1 .. NUM_CELLS
    always_comb begin
        n_wall_len = i_cfg_wall_length;
        if (i_cfg_wall_length == '0) begin
            n_wall_len = LEN_BITS'(1);
        end else if (i_cfg_wall_length > LEN_MAX) begin
            n_wall_len = LEN_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wall_len  <= LEN_MAX;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_wall_len <= n_wall_len;
            end
            if (w_take) begin
                r_out_valid  <= 1'b1;
                r_out_height <= w_res;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    rcst_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (i_cfg_valid),
        .i_wall_len (r_wall_len),
        .i_start    (w_start),
        .i_req      (w_req),
        .i_res_take (w_take),
        .o_stat     (w_stat),
        .o_res      (w_res)
    );

    assign o_valid       = r_out_valid;
    assign o_cell_height = r_out_height;

endmodule

FILE: verif/range_clamp_segment_tree_test.sv
// Testbench for range_clamp_segment_tree: directed and random raise, lower and read requests,
// checked against a cell-height array model. Depends on rcst_pkg and the block's RTL.
module range_clamp_segment_tree_test;
    import rcst_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE_CYCLES = 300;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic [1:0]             i_cmd = '0;
    logic [POS_BITS-1:0]    i_range_start = '0;
    logic [POS_BITS-1:0]    i_range_end = '0;
    logic [HEIGHT_BITS-1:0] i_bound_height = '0;
    logic [POS_BITS-1:0]    i_cell_index = '0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic [HEIGHT_BITS-1:0] o_cell_height;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [LEN_BITS-1:0]    i_cfg_wall_length = '0;

    range_clamp_segment_tree DUT (
        .i_clk, .i_rst_n,
        .i_valid, .o_stall, .i_cmd, .i_range_start, .i_range_end,
        .i_bound_height, .i_cell_index,
        .o_valid, .i_stall, .o_cell_height,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_wall_length
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // model of the wall: plain per-cell heights, clamps applied directly
    logic [HEIGHT_BITS-1:0] wall_height [NUM_CELLS];
    int                     wall_len;
    logic [HEIGHT_BITS-1:0] height_queue [$];
    bit                     failed = 1'b0;
    bit                     quiet = 1'b0;      // no idling on either side while set
    int                     hold_request = 0;  // long receiver hold-off, in cycles
    int                     hold_left = 0;
    int                     cycles = 0;

    // a length write clears the wall; value saturates to 1 .. NUM_CELLS
    task automatic reset_wall(input int len);
        foreach (wall_height[k]) wall_height[k] = '0;
        wall_len = (len < 1) ? 1 : (len > NUM_CELLS ? NUM_CELLS : len);
    endtask

    task automatic apply_request(input logic [1:0] cmd, input int a, input int b,
                                 input logic [HEIGHT_BITS-1:0] h, input int idx);
        int last;
        case (cmd)
            CMD_READ: begin
                height_queue.push_back(idx < wall_len ? wall_height[idx] : '0);
            end
            CMD_RAISE, CMD_LOWER: begin
                // empty range or range past the wall does nothing; end cut to the wall
                if (a <= b && a < wall_len) begin
                    last = (b >= wall_len) ? wall_len - 1 : b;
                    for (int k = a; k <= last; k++) begin
                        if (cmd == CMD_RAISE) begin
                            if (wall_height[k] < h) wall_height[k] = h;
                        end else begin
                            if (wall_height[k] > h) wall_height[k] = h;
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    // one request: offered at this edge, held until accepted; valid left high unless a random gap follows
    task automatic send_request(input logic [1:0] cmd, input int a, input int b,
                                input logic [HEIGHT_BITS-1:0] h, input int idx);
        i_valid        <= 1'b1;
        i_cmd          <= cmd;
        i_range_start  <= a[POS_BITS-1:0];
        i_range_end    <= b[POS_BITS-1:0];
        i_bound_height <= h;
        i_cell_index   <= idx[POS_BITS-1:0];
        do @(posedge i_clk); while (o_stall);
        apply_request(cmd, a, b, h, idx);
        if (!quiet && $urandom_range(99) < 20) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (height_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // only written with the block idle
    task automatic write_length(input int len);
        drain_results();
        i_cfg_valid       <= 1'b1;
        i_cfg_wall_length <= len[LEN_BITS-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        reset_wall(len);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_request(input bit wide_heights);
        int r, a, b;
        logic [HEIGHT_BITS-1:0] h;
        r = $urandom_range(99);
        a = $urandom_range(wall_len - 1);
        b = $urandom_range(a, wall_len - 1);
        h = wide_heights ? HEIGHT_BITS'($urandom) : HEIGHT_BITS'($urandom_range(40));
        if ($urandom_range(19) == 0) h = ($urandom_range(1)) ? HEIGHT_MAX : '0;
        if (r < 30)
            send_request(CMD_RAISE, a, b, h, $urandom_range(NUM_CELLS - 1));
        else if (r < 55)
            send_request(CMD_LOWER, a, b, h, $urandom_range(NUM_CELLS - 1));
        else if (r < 90)
            send_request(CMD_READ, $urandom_range(NUM_CELLS - 1),
                         $urandom_range(NUM_CELLS - 1), h, $urandom_range(wall_len - 1));
        else if (r < 93)
            // noise: raise or lower with any range, bound and index, including empty and past-the-wall ranges
            send_request(2'($urandom_range(1)), $urandom_range(NUM_CELLS - 1),
                         $urandom_range(NUM_CELLS - 1), HEIGHT_BITS'($urandom),
                         $urandom_range(NUM_CELLS - 1));
        else if (r < 97)
            send_request(CMD_READ, 0, 0, h, $urandom_range(NUM_CELLS - 1));
        else
            send_request(CMD_UNUSED, a, b, h, $urandom_range(NUM_CELLS - 1));
    endtask

    task automatic test_directed();
        send_request(CMD_READ, 0, 0, '0, 0);
        send_request(CMD_READ, 0, 0, '0, NUM_CELLS - 1);
        send_request(CMD_RAISE, 0, NUM_CELLS - 1, HEIGHT_MAX, 0);
        send_request(CMD_READ, 0, 0, '0, 0);
        send_request(CMD_READ, 0, 0, '0, NUM_CELLS - 1);
        send_request(CMD_LOWER, 100, 600, 16'h1234, 0);
        send_request(CMD_READ, 0, 0, '0, 99);
        send_request(CMD_READ, 0, 0, '0, 100);
        send_request(CMD_READ, 0, 0, '0, 600);
        send_request(CMD_READ, 0, 0, '0, 601);
        send_request(CMD_LOWER, 700, 300, '0, 0);       // empty range
        send_request(CMD_READ, 0, 0, '0, 500);
        send_request(CMD_UNUSED, 0, NUM_CELLS - 1, '0, 5);
        send_request(CMD_RAISE, 512, 512, 16'h8000, 0);
        send_request(CMD_READ, 0, 0, '0, 512);
        send_request(CMD_LOWER, 0, NUM_CELLS - 1, '0, 0);
        send_request(CMD_READ, 0, 0, '0, 512);
        // short wall: ranges past the wall and reads past it
        write_length(10);
        send_request(CMD_RAISE, 5, NUM_CELLS - 1, 16'h00ff, 0);
        send_request(CMD_RAISE, 10, 20, 16'h0f0f, 0);
        send_request(CMD_READ, 0, 0, '0, 9);
        send_request(CMD_READ, 0, 0, '0, 10);
        send_request(CMD_READ, 0, 0, '0, NUM_CELLS - 1);
        write_length(0);     // saturates to one cell
        send_request(CMD_RAISE, 0, 3, 16'h0042, 0);
        send_request(CMD_READ, 0, 0, '0, 0);
        send_request(CMD_READ, 0, 0, '0, 1);
        write_length(2047);  // saturates to the full tree
    endtask

    task automatic test_random(input int len, input int count);
        write_length(len);
        for (int n = 0; n < count; n++) begin
            quiet = (n >= count / 3 && n < count / 3 + 60);
            random_request(n % 2 == 0);
        end
        quiet = 1'b0;
    endtask

    // receiver holds off while reads keep coming: the block fills and stalls its input
    task automatic test_backpressure();
        drain_results();
        hold_request = 400;
        @(posedge i_clk);
        for (int n = 0; n < 12; n++)
            send_request(CMD_READ, 0, 0, '0, $urandom_range(wall_len - 1));
    endtask

    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !quiet && ($urandom_range(99) < 20);
        end
    end

    // result checker: each accepted height against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (height_queue.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d",
                         $time, o_cell_height);
                failed = 1'b1;
            end else if (o_cell_height !== height_queue[0]) begin
                $display("%0t: cell_height mismatch, expected %0d, actual %0d",
                         $time, height_queue[0], o_cell_height);
                failed = 1'b1;
                void'(height_queue.pop_front());
            end else begin
                void'(height_queue.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        reset_wall(1024);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(NUM_CELLS, 700);
        test_backpressure();
        test_random(2, 250);
        test_random(37, 300);
        test_random($urandom_range(1, NUM_CELLS), 300);
        test_random(1, 100);
        test_random(1000, 300);
        drain_results();
        if (!failed && height_queue.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: range_clamp_segment_tree.f
src/rcst_pkg.sv
src/rcst_tag_ram.sv
src/rcst_engine.sv
src/range_clamp_segment_tree.sv
verif/range_clamp_segment_tree_test.sv
